FILE: hw/rtl/chm_pkg.sv
// Package with the shared constants of the convex hull block.
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

    // Default capacity of the point store.
    localparam int CHM_MAX_POINTS  = 64;

    // Default width of one signed coordinate.
    localparam int CHM_COORD_WIDTH = 16;

endpackage : chm_pkg

`default_nettype wire

FILE: hw/rtl/chm_if.sv
// Valid/ready channel interfaces for input points and hull vertices.
`timescale 1ns / 1ps
`default_nettype none

interface chm_in_if #(
    parameter int COORD_WIDTH = chm_pkg::CHM_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          final_point;

    modport source (output valid, point_x, point_y, final_point, input ready);
    modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface : chm_in_if

interface chm_out_if #(
    parameter int COORD_WIDTH = chm_pkg::CHM_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] hull_x;
    logic signed [COORD_WIDTH-1:0] hull_y;
    logic                          last_vertex;
    logic                          overflowed;

    modport source (output valid, hull_x, hull_y, last_vertex, overflowed, input ready);
    modport sink   (input valid, hull_x, hull_y, last_vertex, overflowed, output ready);
endinterface : chm_out_if

`default_nettype wire

FILE: hw/rtl/chm_cross.sv
// Turn test a -> b -> c by a cross product on one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module chm_cross #(
    parameter int COORD_WIDTH = chm_pkg::CHM_COORD_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [2*COORD_WIDTH-1:0] pa,
    input  wire logic [2*COORD_WIDTH-1:0] pb,
    input  wire logic [2*COORD_WIDTH-1:0] pc,
    output logic                          done,
    output logic                          right_turn
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int RW = PW + 1;

    logic [W-1:0] ax, ay, bx, by, cx, cy;

    logic signed [DW-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [DW-1:0] d1_next, d2_next, d3_next, d4_next;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] prod1_reg, prod2_reg;
    logic        [RW-1:0] diff;
    logic                 turn_reg;
    logic [3:0]           stage_reg;

    assign ax = pa[2*W-1:W];
    assign ay = pa[W-1:0];
    assign bx = pb[2*W-1:W];
    assign by = pb[W-1:0];
    assign cx = pc[2*W-1:W];
    assign cy = pc[W-1:0];

    // Coordinate differences, one bit wider than a coordinate.
    assign d1_next = {bx[W-1], bx} - {ax[W-1], ax};
    assign d2_next = {cy[W-1], cy} - {ay[W-1], ay};
    assign d3_next = {by[W-1], by} - {ay[W-1], ay};
    assign d4_next = {cx[W-1], cx} - {ax[W-1], ax};

    // One multiplier forms the two products in consecutive cycles.
    assign mul_a = stage_reg[1] ? d3_reg : d1_reg;
    assign mul_b = stage_reg[1] ? d4_reg : d2_reg;
    assign mul_p = mul_a * mul_b;

    // A negative cross product is a strict right turn.
    assign diff = {prod1_reg[PW-1], prod1_reg} - {prod2_reg[PW-1], prod2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            d3_reg <= d3_next;
            d4_reg <= d4_next;
        end
        if (stage_reg[0])
        begin
            prod1_reg <= mul_p;
        end
        if (stage_reg[1])
        begin
            prod2_reg <= mul_p;
        end
        if (stage_reg[2])
        begin
            turn_reg <= diff[RW-1];
        end
    end

    assign done       = stage_reg[3];
    assign right_turn = turn_reg;

endmodule : chm_cross

`default_nettype wire

FILE: hw/rtl/convex_hull_monotone_chain.sv
// Convex hull by the monotone chain method over points stored in on-chip memory.
//
//  channel  | role   | item                                        | accepted when
//  points   | sink   | point_x, point_y, final_point               | valid && ready
//  hull     | source | hull_x, hull_y, last_vertex, overflowed     | valid && ready
//
// While loading, a point is taken whenever valid is high; ready is high only while the block loads.
// With three or more points, an in-place insertion sort runs after the final item over the
// point memory at one compare per cycle, then the two chain passes fetch each point and
// run the turn tests, paced by the cross product unit and the registered memory read.
// Each vertex then waits out any stall on the hull side.
// Reset clears the point count and the overflow flag; the memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module convex_hull_monotone_chain #(
    parameter int MAX_POINTS  = chm_pkg::CHM_MAX_POINTS,
    parameter int COORD_WIDTH = chm_pkg::CHM_COORD_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    chm_in_if.sink     points,
    chm_out_if.source  hull
);

    localparam int W     = COORD_WIDTH;
    localparam int PI    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CI    = $clog2(2 * MAX_POINTS);

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
    } pt_t;

    typedef enum logic [13:0] {
        S_LOAD    = 14'b00000000000001,
        S_SORT_I  = 14'b00000000000010,
        S_SORT_P  = 14'b00000000000100,
        S_SORT_C  = 14'b00000000001000,
        S_SORT_W0 = 14'b00000000010000,
        S_B_RD    = 14'b00000000100000,
        S_B_GET   = 14'b00000001000000,
        S_B_CHK   = 14'b00000010000000,
        S_X_WAIT  = 14'b00000100000000,
        S_PUSH    = 14'b00001000000000,
        S_POP_W   = 14'b00010000000000,
        S_E_RD    = 14'b00100000000000,
        S_E_LAT   = 14'b01000000000000,
        S_E_OUT   = 14'b10000000000000
    } state_t;

    // Memories: sorted points in place, and both chains as stacks in one array.
    pt_t pm [MAX_POINTS];
    pt_t cm [2*MAX_POINTS];

    logic          pm_we;
    logic [PI-1:0] pm_waddr, pm_raddr;
    pt_t           pm_wdata, pm_rd;
    logic          cm_we;
    logic [CI-1:0] cm_waddr, cm_raddr;
    pt_t           cm_wdata, cm_rd;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    pt_t              first_reg, first_next;
    pt_t              p_reg, p_next;
    pt_t              t1_reg, t1_next;
    pt_t              t2_reg, t2_next;
    logic [PI-1:0]    i_reg, i_next;
    logic [PI-1:0]    j_reg, j_next;
    logic [CI-1:0]    sp_reg, sp_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic [CI-1:0]    nu_reg, nu_next;
    logic [CI-1:0]    total_reg, total_next;
    logic [CI-1:0]    eidx_reg, eidx_next;
    logic             src_cm_reg, src_cm_next;
    logic             upper_reg, upper_next;
    logic             out_valid_reg, out_valid_next;
    pt_t              out_pt_reg, out_pt_next;
    logic             last_reg, last_next;

    logic             acc;
    pt_t              in_pt;
    logic             room;
    logic             i_is_end;
    logic             p_less;
    logic             x_start;
    logic             x_done;
    logic             x_right;

    assign acc        = points.valid && points.ready;
    assign in_pt.x    = points.point_x;
    assign in_pt.y    = points.point_y;
    assign room       = (count_reg < CNT_W'(MAX_POINTS));
    assign i_is_end   = ({1'b0, i_reg} == count_reg - CNT_W'(1));
    assign p_less     = (p_reg.x < pm_rd.x) || ((p_reg.x == pm_rd.x) && (p_reg.y < pm_rd.y));

    assign points.ready = (state_reg == S_LOAD);

    // Cross product unit for the turn test on the two stack tops and the new point.
    chm_cross #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (x_start),
        .pa         (t2_reg),
        .pb         (t1_reg),
        .pc         (p_reg),
        .done       (x_done),
        .right_turn (x_right)
    );

    // Sequencer: load, sort, two chain passes, emit; one or two points go straight to emit.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        first_next     = first_reg;
        p_next         = p_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        sp_next        = sp_reg;
        size_next      = size_reg;
        nu_next        = nu_reg;
        total_next     = total_reg;
        eidx_next      = eidx_reg;
        src_cm_next    = src_cm_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg;
        out_pt_next    = out_pt_reg;
        last_next      = last_reg;
        pm_we          = 1'b0;
        pm_waddr       = count_reg[PI-1:0];
        pm_wdata       = in_pt;
        pm_raddr       = i_reg;
        cm_we          = 1'b0;
        cm_waddr       = sp_reg;
        cm_wdata       = p_reg;
        cm_raddr       = sp_reg - CI'(3);
        x_start        = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (acc)
                begin
                    if (room)
                    begin
                        pm_we      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == '0)
                        begin
                            first_next = in_pt;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (points.final_point)
                    begin
                        eidx_next   = '0;
                        src_cm_next = 1'b0;
                        if (room && (count_reg == '0))
                        begin
                            // A single point is its own hull.
                            total_next = CI'(1);
                            state_next = S_E_RD;
                        end
                        else if (room && (count_reg == CNT_W'(1)))
                        begin
                            // Two points: both in arrival order unless they coincide.
                            total_next = (in_pt == first_reg) ? CI'(1) : CI'(2);
                            state_next = S_E_RD;
                        end
                        else
                        begin
                            i_next     = PI'(1);
                            state_next = S_SORT_I;
                        end
                    end
                end
            end

            S_SORT_I:
            begin
                pm_raddr   = i_reg;
                state_next = S_SORT_P;
            end

            S_SORT_P:
            begin
                p_next     = pm_rd;
                pm_raddr   = i_reg - PI'(1);
                j_next     = i_reg;
                state_next = S_SORT_C;
            end

            S_SORT_C:
            begin
                pm_we    = 1'b1;
                pm_waddr = j_reg;
                if (p_less)
                begin
                    // Shift the larger point up one place and look further down.
                    pm_wdata = pm_rd;
                    pm_raddr = j_reg - PI'(2);
                    j_next   = j_reg - PI'(1);
                    if (j_reg == PI'(1))
                    begin
                        state_next = S_SORT_W0;
                    end
                end
                else
                begin
                    pm_wdata = p_reg;
                    if (i_is_end)
                    begin
                        i_next     = '0;
                        sp_next    = '0;
                        size_next  = '0;
                        upper_next = 1'b1;
                        state_next = S_B_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + PI'(1);
                        state_next = S_SORT_I;
                    end
                end
            end

            S_SORT_W0:
            begin
                pm_we    = 1'b1;
                pm_waddr = '0;
                pm_wdata = p_reg;
                if (i_is_end)
                begin
                    i_next     = '0;
                    sp_next    = '0;
                    size_next  = '0;
                    upper_next = 1'b1;
                    state_next = S_B_RD;
                end
                else
                begin
                    i_next     = i_reg + PI'(1);
                    state_next = S_SORT_I;
                end
            end

            S_B_RD:
            begin
                pm_raddr   = i_reg;
                state_next = S_B_GET;
            end

            S_B_GET:
            begin
                p_next     = pm_rd;
                state_next = S_B_CHK;
            end

            S_B_CHK:
            begin
                if (size_reg >= CNT_W'(2))
                begin
                    x_start    = 1'b1;
                    state_next = S_X_WAIT;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            S_X_WAIT:
            begin
                if (x_done)
                begin
                    if (x_right)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        // Pop the top and fetch the new second entry from memory.
                        sp_next    = sp_reg - CI'(1);
                        size_next  = size_reg - CNT_W'(1);
                        t1_next    = t2_reg;
                        cm_raddr   = sp_reg - CI'(3);
                        state_next = S_POP_W;
                    end
                end
            end

            S_POP_W:
            begin
                t2_next    = cm_rd;
                state_next = S_B_CHK;
            end

            S_PUSH:
            begin
                cm_we     = 1'b1;
                cm_waddr  = sp_reg;
                cm_wdata  = p_reg;
                t2_next   = t1_reg;
                t1_next   = p_reg;
                sp_next   = sp_reg + CI'(1);
                size_next = size_reg + CNT_W'(1);
                if (upper_reg)
                begin
                    if (i_is_end)
                    begin
                        // The lower chain starts on the last upper entry.
                        nu_next    = sp_reg + CI'(1);
                        sp_next    = sp_reg;
                        size_next  = '0;
                        upper_next = 1'b0;
                        state_next = S_B_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + PI'(1);
                        state_next = S_B_RD;
                    end
                end
                else
                begin
                    if (i_reg == '0)
                    begin
                        total_next  = nu_reg + CI'(size_reg) - CI'(1);
                        eidx_next   = '0;
                        src_cm_next = 1'b1;
                        state_next  = S_E_RD;
                    end
                    else
                    begin
                        i_next     = i_reg - PI'(1);
                        state_next = S_B_RD;
                    end
                end
            end

            S_E_RD:
            begin
                pm_raddr   = eidx_reg[PI-1:0];
                cm_raddr   = eidx_reg;
                state_next = S_E_LAT;
            end

            S_E_LAT:
            begin
                out_pt_next    = src_cm_reg ? cm_rd : pm_rd;
                last_next      = (eidx_reg == total_reg - CI'(1));
                out_valid_next = 1'b1;
                state_next     = S_E_OUT;
            end

            S_E_OUT:
            begin
                if (hull.ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        eidx_next  = eidx_reg + CI'(1);
                        state_next = S_E_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            sp_reg        <= '0;
            size_reg      <= '0;
            nu_reg        <= '0;
            total_reg     <= '0;
            eidx_reg      <= '0;
            src_cm_reg    <= 1'b0;
            upper_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            sp_reg        <= sp_next;
            size_reg      <= size_next;
            nu_reg        <= nu_next;
            total_reg     <= total_next;
            eidx_reg      <= eidx_next;
            src_cm_reg    <= src_cm_next;
            upper_reg     <= upper_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        p_reg      <= p_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        out_pt_reg <= out_pt_next;
        last_reg   <= last_next;
    end

    // Point memory, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pm[pm_waddr] <= pm_wdata;
        end
        pm_rd <= pm[pm_raddr];
    end

    // Chain memory, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            cm[cm_waddr] <= cm_wdata;
        end
        cm_rd <= cm[cm_raddr];
    end

    assign hull.valid       = out_valid_reg;
    assign hull.hull_x      = out_pt_reg.x;
    assign hull.hull_y      = out_pt_reg.y;
    assign hull.last_vertex = last_reg;
    assign hull.overflowed  = ovf_reg;

endmodule : convex_hull_monotone_chain

`default_nettype wire

FILE: tb/sv/convex_hull_monotone_chain_test.sv
// Self-checking testbench for the monotone chain convex hull block.
`timescale 1ns / 1ps
`default_nettype none

module convex_hull_monotone_chain_test;

    localparam int MAXP = chm_pkg::CHM_MAX_POINTS;
    localparam int CW   = chm_pkg::CHM_COORD_WIDTH;
    localparam int STALL_LIMIT = 200000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last_vertex;
        logic   overflowed;
    } vertex_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   final_point;
        logic   has_typed;
        coord_t typed_x;
        coord_t typed_y;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    chm_in_if  #(.COORD_WIDTH(CW)) points ();
    chm_out_if #(.COORD_WIDTH(CW)) hull ();

    convex_hull_monotone_chain #(.MAX_POINTS(MAXP), .COORD_WIDTH(CW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points.sink),
        .hull   (hull.source)
    );

    // Clock with a period of 8 ns.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Model state: points loaded so far in the current set.
    point_t  loaded_pts[$];
    logic    set_overflow = 1'b0;
    vertex_t hull_expect[$];

    int error_count = 0;
    int typed_errors = 0;
    int sets_done = 0;
    int vertices_seen = 0;
    int overflow_sets = 0;
    int idle_in_pct = 0;
    int stall_out_pct = 0;
    int quiet_cycles = 0;

    // Strict right turn of a -> b -> c.
    function automatic logic is_right_turn(point_t a, point_t b, point_t c);
        longint cr;
        cr = (longint'(b.x) - a.x) * (longint'(c.y) - a.y)
           - (longint'(b.y) - a.y) * (longint'(c.x) - a.x);
        return cr < 0;
    endfunction

    function automatic logic pt_before(point_t a, point_t b);
        return (a.x < b.x) || (a.x == b.x && a.y < b.y);
    endfunction

    // Work out the hull vertices of the loaded set and queue them.
    task automatic queue_hull();
        point_t sorted[$];
        point_t up[$];
        point_t lo[$];
        point_t p;
        int n;
        int j;
        n = loaded_pts.size();
        if (n == 0)
            return;
        if (n <= 2)
        begin
            up.insert(up.size(), loaded_pts[0]);
            if (n == 2 && loaded_pts[1] != loaded_pts[0])
                up.insert(up.size(), loaded_pts[1]);
        end
        else
        begin
            // Insertion sort by x, then y.
            foreach (loaded_pts[i])
            begin
                p = loaded_pts[i];
                j = sorted.size();
                while (j > 0 && pt_before(p, sorted[j-1]))
                    j--;
                sorted.insert(j, p);
            end
            up.insert(up.size(), sorted[0]);
            up.insert(up.size(), sorted[1]);
            for (int i = 2; i < n; i++)
            begin
                up.insert(up.size(), sorted[i]);
                while (up.size() >= 3 &&
                       !is_right_turn(up[up.size()-3], up[up.size()-2], up[up.size()-1]))
                    up.delete(up.size()-2);
            end
            lo.insert(lo.size(), sorted[n-1]);
            lo.insert(lo.size(), sorted[n-2]);
            for (int i = n - 3; i >= 0; i--)
            begin
                lo.insert(lo.size(), sorted[i]);
                while (lo.size() >= 3 &&
                       !is_right_turn(lo[lo.size()-3], lo[lo.size()-2], lo[lo.size()-1]))
                    lo.delete(lo.size()-2);
            end
            for (int i = 1; i + 1 < lo.size(); i++)
                up.insert(up.size(), lo[i]);
        end
        foreach (up[i])
            hull_expect.insert(hull_expect.size(),
                               vertex_t'{up[i].x, up[i].y, i == up.size() - 1, set_overflow});
    endtask

    // Update the model with one accepted point.
    task automatic take_point(coord_t x, coord_t y, logic fin);
        if (loaded_pts.size() < MAXP)
            loaded_pts.insert(loaded_pts.size(), point_t'{x, y});
        else
            set_overflow = 1'b1;
        if (fin)
        begin
            queue_hull();
            if (set_overflow)
                overflow_sets++;
            sets_done++;
            loaded_pts.delete();
            set_overflow = 1'b0;
        end
    endtask

    // Receiver: random stall at the falling edge, checks at the rising edge.
    always @(negedge clk)
        hull.ready <= ($urandom_range(99) >= stall_out_pct);

    always @(posedge clk)
    begin
        if (rst_n && hull.valid && hull.ready)
        begin
            vertices_seen++;
            if (hull_expect.size() == 0)
            begin
                $error("hull vertex with none expected: x=%0d y=%0d", hull.hull_x, hull.hull_y);
                error_count++;
            end
            else
            begin
                vertex_t e;
                e = hull_expect.pop_front();
                if (hull.hull_x !== e.x)
                begin
                    $error("hull_x: expected %0d, got %0d", e.x, hull.hull_x);
                    error_count++;
                end
                if (hull.hull_y !== e.y)
                begin
                    $error("hull_y: expected %0d, got %0d", e.y, hull.hull_y);
                    error_count++;
                end
                if (hull.last_vertex !== e.last_vertex)
                begin
                    $error("last_vertex: expected %0b, got %0b", e.last_vertex, hull.last_vertex);
                    error_count++;
                end
                if (hull.overflowed !== e.overflowed)
                begin
                    $error("overflowed: expected %0b, got %0b", e.overflowed, hull.overflowed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if ((points.valid && points.ready) || (hull.valid && hull.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d vertices outstanding", hull_expect.size());
            $display("convex_hull_monotone_chain_test: errors");
            $finish;
        end
    end

    // Present one point and wait until it is accepted. Valid stays up so that a
    // following item can go back to back; an idle gap in the next call or a drain lowers it.
    task automatic send_point(coord_t x, coord_t y, logic fin);
        while ($urandom_range(99) < idle_in_pct)
        begin
            points.valid <= 1'b0;
            @(negedge clk);
        end
        points.valid       <= 1'b1;
        points.point_x     <= x;
        points.point_y     <= y;
        points.final_point <= fin;
        @(posedge clk);
        while (!points.ready)
            @(posedge clk);
        take_point(x, y, fin);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected vertex has come out.
    task automatic wait_drained();
        points.valid <= 1'b0;
        while (hull_expect.size() != 0)
            @(negedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'(16'sh7fff);
            1: return coord_t'(16'sh8000);
            2: return coord_t'(int'($urandom_range(20)) - 10);
            default: return coord_t'($urandom());
        endcase
    endfunction

    // Random set: mostly small, now and then full or past capacity.
    task automatic send_random_set(output int sent);
        int n;
        int kind;
        coord_t bx;
        coord_t by;
        kind = $urandom_range(19);
        if (kind == 0)
            n = MAXP + $urandom_range(3);
        else if (kind == 1)
            n = MAXP;
        else
            n = 1 + $urandom_range(11);
        bx = rand_coord();
        by = rand_coord();
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(7))
                0: send_point(bx, by, i == n - 1);
                1: send_point(bx, coord_t'($urandom()), i == n - 1);
                2: send_point(bx + coord_t'(i), by + coord_t'(2 * i), i == n - 1);
                default: send_point(rand_coord(), rand_coord(), i == n - 1);
            endcase
        end
        sent = n;
    endtask

    stim_row_t directed[$];

    initial
    begin
        int item_total;
        int phase_items;
        int sent;
        bit ok;

        points.valid       = 1'b0;
        points.point_x     = '0;
        points.point_y     = '0;
        points.final_point = 1'b0;

        // Directed rows; typed results are checked against the model as well.
        directed = '{
            '{16'sh7fff, 16'sh8000, 1'b1, 1'b1, 16'sh7fff, 16'sh8000},
            '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, 16'sh8000, 16'sh7fff},
            '{16'sh0005, 16'sh0005, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0005, 16'sh0005, 1'b1, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0003, 16'sh0001, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{-16'sd2,   16'sh0009, 1'b1, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0001, 16'sh0001, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0001, 16'sh0001, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0001, 16'sh0001, 1'b1, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0002, 16'sh0002, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0004, 16'sh0004, 1'b1, 1'b0, 16'sh0, 16'sh0},
            '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, 16'sh0, 16'sh0},
            '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'sh0, 16'sh0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_in_pct = 22;
        stall_out_pct = 81;
        item_total = 0;
        foreach (directed[r])
        begin
            send_point(directed[r].x, directed[r].y, directed[r].final_point);
            item_total++;
            if (directed[r].has_typed)
            begin
                ok = hull_expect.size() == 1 && hull_expect[0].x == directed[r].typed_x
                     && hull_expect[0].y == directed[r].typed_y
                     && hull_expect[0].last_vertex;
                if (!ok)
                begin
                    $error("single point row %0d: model disagrees with typed vertex", r);
                    typed_errors++;
                end
            end
        end

        // Overflow: capacity plus two, the dropped last item closes the set.
        for (int i = 0; i < MAXP + 2; i++)
        begin
            send_point(coord_t'($urandom()), coord_t'($urandom()), i == MAXP + 1);
            item_total++;
        end
        wait_drained();

        // Random part over three idling phases.
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_in_pct   = (ph == 0) ? 22 : (ph == 1) ? 81 : 0;
            stall_out_pct = (ph == 0) ? 81 : (ph == 1) ? 22 : 0;
            phase_items = 0;
            while (phase_items < 80)
            begin
                send_random_set(sent);
                phase_items += sent;
                if ($urandom_range(3) == 0)
                    wait_drained();
            end
            item_total += phase_items;
        end

        wait_drained();
        repeat (200) @(negedge clk);

        $display("Covered %0d points in %0d sets, %0d of them past capacity.",
                 item_total, sets_done, overflow_sets);
        $display("Checked %0d hull vertices under three idling patterns.", vertices_seen);
        if (error_count == 0 && typed_errors == 0 && hull_expect.size() == 0)
            $display("convex_hull_monotone_chain_test: clean");
        else
            $display("convex_hull_monotone_chain_test: errors");
        $finish;
    end

endmodule : convex_hull_monotone_chain_test

`default_nettype wire
